// ===== sv/knn_pkg.sv =====
// Shared constants, types and helpers for the k-nearest-neighbour anomaly score core.
// Depends on nothing; every other file but knn_ram imports it.
package knn_pkg;
   localparam int TableDepthDefault    = 1024;
   localparam int FeatureCountDefault  = 8;
   localparam int NeighborCountDefault = 3;
   localparam int FeatureBitsDefault   = 16;
   localparam int IndexBits     = 10;
   localparam int CountBits     = 11;
   localparam int ScoreBits     = 20;
   localparam int AccBits       = 64;
   localparam int RootBits      = 32;

   localparam logic [0:0] OpWrite = 1'b0;
   localparam logic [0:0] OpQuery = 1'b1;

   localparam logic [0:0] CsrEntries   = 1'b0;
   localparam logic [0:0] CsrThreshold = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_entry;   // store the vector held at the ports
      logic load_query;    // read the query vector from the table
      logic capture_query; // latch the query vector from the read port
      logic issue_read;    // read one candidate entry
      logic clear_slots;   // empty the neighbour slots
      logic finish;        // form the score and strobe the result
   } knn_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_issued;   // the final candidate read has been issued
      logic pipe_empty;    // no candidate remains in flight
   } knn_status_type;
endpackage

// ===== sv/knn_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on nothing.
module knn_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/knn_isqrt.sv =====
// Pipelined integer square root, two result bits settled per stage.
// Depends on knn_pkg.
module knn_isqrt import knn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [AccBits-1:0]  in_value,
   output logic                out_valid,
   output logic [RootBits-1:0] out_root
);
   localparam int Stages = RootBits / 2;

   // Remainder, partial root and valid bit entering each stage.
   logic [AccBits-1:0]  rem_stage  [Stages+1];
   logic [RootBits-1:0] root_stage [Stages+1];
   logic                vld_stage  [Stages+1];

   assign rem_stage[0]  = in_value;
   assign root_stage[0] = '0;
   assign vld_stage[0]  = in_valid;

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [AccBits-1:0]  rem_mid;
      logic [RootBits-1:0] root_mid;
      logic [AccBits-1:0]  shifted;
      logic [AccBits+1:0]  trial;
      logic [AccBits-1:0]  rem_ff;
      logic [RootBits-1:0] root_ff;
      logic                vld_ff;

      // Restoring digit step: each stage resolves two root bits.
      always_comb begin
         rem_mid  = rem_stage[s];
         root_mid = root_stage[s];
         shifted  = '0;
         trial    = '0;
         for (int b = 0; b < 2; b++) begin
            shifted = AccBits'(root_mid) << (RootBits - 2*s - b);
            trial   = {2'b00, shifted}
                    + ({2'b00, AccBits'(1)} << (2*(RootBits - 2*s - b - 1)));
            if ({2'b00, rem_mid} >= trial) begin
               rem_mid  = rem_mid - trial[AccBits-1:0];
               root_mid = root_mid | (RootBits'(1) << (RootBits - 2*s - b - 1));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_stage[s];
         end
         rem_ff  <= rem_mid;
         root_ff <= root_mid;
      end

      assign rem_stage[s+1]  = rem_ff;
      assign root_stage[s+1] = root_ff;
      assign vld_stage[s+1]  = vld_ff;
   end

   assign out_valid = vld_stage[Stages];
   assign out_root  = root_stage[Stages];
endmodule

// ===== sv/knn_datapath.sv =====
// Datapath: reference table, distance pipeline, square root and neighbour slots.
// Depends on knn_pkg, knn_ram and knn_isqrt.
module knn_datapath import knn_pkg::*; #(
   parameter int TableDepth    = TableDepthDefault,
   parameter int FeatureCount  = FeatureCountDefault,
   parameter int NeighborCount = NeighborCountDefault,
   parameter int FeatureBits   = FeatureBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  knn_cmd_type                         cmd,
   output knn_status_type                      status,
   input  logic [IndexBits-1:0]                entry_index,
   input  logic [FeatureCount*FeatureBits-1:0] vector,
   input  logic [CountBits-1:0]                entries_in_use,
   input  logic [ScoreBits-1:0]                score_threshold,
   output logic                                rsp_valid,
   output logic [ScoreBits-1:0]                rsp_score,
   output logic                                rsp_is_anomaly
);
   localparam int AddrBits  = $clog2(TableDepth);
   localparam int Width     = FeatureCount * FeatureBits;
   localparam int DiffBits  = FeatureBits + 1;
   localparam int SqBits    = 2 * DiffBits;
   localparam int CntBits   = AddrBits + 1;
   localparam int SlotBits  = (NeighborCount > 1) ? $clog2(NeighborCount) : 1;
   localparam int FillBits  = $clog2(NeighborCount + 1);
   localparam int RecipShift = 2 * IndexBits;
   localparam longint Recip = ((longint'(1) << RecipShift) + TableDepth - 1) / TableDepth;

   // Table access address: the write/query slot, or the candidate counter.
   logic [CntBits-1:0]  cand_ff, cand_in, limit;
   logic [AddrBits-1:0] addr;
   logic [Width-1:0]    rd_data;
   logic [Width-1:0]    query_ff;
   logic                rd_vld_ff;
   logic [AddrBits-1:0] slot;

   // An index wraps modulo the table depth; the quotient comes from a
   // reciprocal multiplication, exact over the whole index range.
   if (TableDepth >= (1 << IndexBits)) begin : g_slot_direct
      assign slot = AddrBits'(entry_index);
   end else begin : g_slot_wrap
      logic [3*IndexBits-1:0] prod;
      logic [IndexBits-1:0]   quot;
      logic [2*IndexBits-1:0] base;
      assign prod = (3*IndexBits)'(entry_index) * (3*IndexBits)'(Recip);
      assign quot = prod[RecipShift +: IndexBits];
      assign base = (2*IndexBits)'(quot) * (2*IndexBits)'(TableDepth);
      assign slot = AddrBits'((2*IndexBits)'(entry_index) - base);
   end

   assign limit = (32'(entries_in_use) > TableDepth) ? CntBits'(TableDepth)
                                                      : CntBits'(entries_in_use);
   assign addr = (cmd.write_entry || cmd.load_query) ? slot : cand_ff[AddrBits-1:0];

   knn_ram #(.Width(Width), .Depth(TableDepth)) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .addr    (addr),
      .wr_data (vector),
      .rd_data (rd_data)
   );

   always_comb begin
      cand_in = cand_ff;
      if (cmd.clear_slots) begin
         cand_in = '0;
      end else if (cmd.issue_read && cand_ff < limit) begin
         cand_in = cand_ff + 1'b1;
      end
   end

   // Stage 1: per-feature squares.
   logic [SqBits-1:0] sq_ff [FeatureCount];
   logic              sq_vld_ff;
   // Stage 2: saturating sum.
   logic [AccBits-1:0] acc_ff, acc_in;
   logic               acc_vld_ff;

   always_comb begin
      logic [AccBits:0] s;
      s = '0;
      for (int f = 0; f < FeatureCount; f++) begin
         s = s + (AccBits+1)'(sq_ff[f]);
         if (s[AccBits]) s = {1'b0, {AccBits{1'b1}}};
      end
      acc_in = s[AccBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         sq_vld_ff  <= 1'b0;
         acc_vld_ff <= 1'b0;
      end else begin
         cand_ff    <= cand_in;
         rd_vld_ff  <= cmd.issue_read && cand_ff < limit;
         sq_vld_ff  <= rd_vld_ff;
         acc_vld_ff <= sq_vld_ff;
      end
      if (cmd.capture_query) begin
         query_ff <= rd_data;
      end
      for (int f = 0; f < FeatureCount; f++) begin
         logic signed [DiffBits-1:0] d;
         logic [DiffBits-1:0]        m;
         d = DiffBits'($signed(query_ff[f*FeatureBits +: FeatureBits]))
           - DiffBits'($signed(rd_data[f*FeatureBits +: FeatureBits]));
         m = d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
         sq_ff[f] <= SqBits'(m) * SqBits'(m);
      end
      acc_ff <= acc_in;
   end

   logic                cand_dist_vld;
   logic [RootBits-1:0] cand_dist;

   knn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_vld_ff),
      .in_value  (acc_ff),
      .out_valid (cand_dist_vld),
      .out_root  (cand_dist)
   );

   // Neighbour slots: fill in order, then replace the largest if strictly smaller.
   logic [RootBits-1:0] kept_ff [NeighborCount];
   logic [FillBits-1:0] fill_ff;
   logic [SlotBits-1:0] big;

   always_comb begin
      big = '0;
      for (int j = 1; j < NeighborCount; j++) begin
         if (kept_ff[j] > kept_ff[big]) big = SlotBits'(j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_slots) begin
         fill_ff <= '0;
         for (int j = 0; j < NeighborCount; j++) kept_ff[j] <= '0;
      end else if (cand_dist_vld) begin
         if (32'(fill_ff) < NeighborCount) begin
            kept_ff[fill_ff[SlotBits-1:0]] <= cand_dist;
            fill_ff <= fill_ff + 1'b1;
         end else if (cand_dist < kept_ff[big]) begin
            kept_ff[big] <= cand_dist;
         end
      end
   end

   // Saturating score sum.
   logic [ScoreBits-1:0] score;
   always_comb begin
      logic [RootBits:0] s;
      s = '0;
      for (int j = 0; j < NeighborCount; j++) begin
         s = s + (RootBits+1)'(kept_ff[j]);
         if (s > (RootBits+1)'({ScoreBits{1'b1}})) s = (RootBits+1)'({ScoreBits{1'b1}});
      end
      score = s[ScoreBits-1:0];
   end

   logic                 rsp_valid_ff;
   logic [ScoreBits-1:0] rsp_score_ff;
   logic                 rsp_anom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      rsp_score_ff <= score;
      rsp_anom_ff  <= score > score_threshold;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score      = rsp_score_ff;
   assign rsp_is_anomaly = rsp_anom_ff;

   // Square root pipeline occupancy, tracked alongside it.
   localparam int SqrtLat = RootBits / 2;
   logic [SqrtLat-1:0] sqrt_occ_ff;
   logic               u_isqrt_busy;
   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_occ_ff <= '0;
      end else begin
         sqrt_occ_ff <= {sqrt_occ_ff[SqrtLat-2:0], acc_vld_ff};
      end
   end
   assign u_isqrt_busy = |sqrt_occ_ff;

   assign status = '{
      last_issued: !(cand_ff < limit),
      pipe_empty:  !rd_vld_ff && !sq_vld_ff && !acc_vld_ff && !u_isqrt_busy
   };
endmodule

// ===== sv/knn_ctrl.sv =====
// Controller state machine for the anomaly score core.
// Depends on knn_pkg.
module knn_ctrl import knn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [0:0]     op,
   output logic           busy,
   output knn_cmd_type    cmd,
   input  knn_status_type status
);
   localparam logic [2:0] StIdle    = 3'd0;
   localparam logic [2:0] StCapture = 3'd1;
   localparam logic [2:0] StStream  = 3'd2;
   localparam logic [2:0] StDrain   = 3'd3;
   localparam logic [2:0] StFinish  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               if (op == OpWrite) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.load_query  = 1'b1;
                  cmd.clear_slots = 1'b1;
                  state_in = StCapture;
               end
            end
         end
         StCapture: begin
            cmd.capture_query = 1'b1;
            state_in = StStream;
         end
         StStream: begin
            cmd.issue_read = 1'b1;
            if (status.last_issued) state_in = StDrain;
         end
         StDrain: begin
            if (status.pipe_empty) state_in = StFinish;
         end
         StFinish: begin
            cmd.finish = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != StIdle);
endmodule

// ===== sv/knn_anomaly_score_core.sv =====
// k-nearest-neighbour anomaly score core.
// A write item leaves the core idle, and the next item may follow straight away.
// A query compares its entry with each of the N entries in use and strobes its
// result once the last comparison is done, and the next item is taken in that cycle:
// one table read per cycle streams through the distance pipeline and the
// sixteen-stage square root, then the score is formed and strobed for one cycle.
// Synchronous active-high reset clears control state and both registers; the
// table contents are undefined until written. The receiver cannot stall results.
module knn_anomaly_score_core import knn_pkg::*; #(
   parameter int TableDepth    = TableDepthDefault,
   parameter int FeatureCount  = FeatureCountDefault,
   parameter int NeighborCount = NeighborCountDefault,
   parameter int FeatureBits   = FeatureBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [0:0]             req_op,
   input  logic [IndexBits-1:0]   req_entry_index,
   input  logic [FeatureBits-1:0] req_feature_0,
   input  logic [FeatureBits-1:0] req_feature_1,
   input  logic [FeatureBits-1:0] req_feature_2,
   input  logic [FeatureBits-1:0] req_feature_3,
   input  logic [FeatureBits-1:0] req_feature_4,
   input  logic [FeatureBits-1:0] req_feature_5,
   input  logic [FeatureBits-1:0] req_feature_6,
   input  logic [FeatureBits-1:0] req_feature_7,
   input  logic                   csr_wr_en,
   input  logic [0:0]             csr_index,
   input  logic [ScoreBits-1:0]   csr_wr_data,
   output logic                   rsp_valid,
   output logic [ScoreBits-1:0]   rsp_score,
   output logic                   rsp_is_anomaly
);
   // Configuration registers, to be written only while the core is idle; the core does not enforce this.
   logic [CountBits-1:0] entries_ff;
   logic [ScoreBits-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         thresh_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrEntries:   entries_ff <= csr_wr_data[CountBits-1:0];
            CsrThreshold: thresh_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // The features are packed lowest first; positions beyond eight stay zero.
   logic [FeatureCount*FeatureBits-1:0] vector;
   logic [16*FeatureBits-1:0]           all_features;
   assign all_features = {{(8*FeatureBits){1'b0}}, req_feature_7, req_feature_6,
                          req_feature_5, req_feature_4, req_feature_3,
                          req_feature_2, req_feature_1, req_feature_0};
   assign vector = all_features[FeatureCount*FeatureBits-1:0];

   knn_cmd_type    cmd;
   knn_status_type status;

   knn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_op),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   knn_datapath #(
      .TableDepth    (TableDepth),
      .FeatureCount  (FeatureCount),
      .NeighborCount (NeighborCount),
      .FeatureBits   (FeatureBits)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .entry_index     (req_entry_index),
      .vector          (vector),
      .entries_in_use  (entries_ff),
      .score_threshold (thresh_ff),
      .rsp_valid       (rsp_valid),
      .rsp_score       (rsp_score),
      .rsp_is_anomaly  (rsp_is_anomaly)
   );
endmodule

// ===== sim/knn_anomaly_score_core_test.sv =====
// Self-checking testbench for the k-nearest-neighbour anomaly score core.
// Depends on knn_pkg and knn_anomaly_score_core with its submodules.
`timescale 1ns / 100ps

module knn_anomaly_score_core_test;
   import knn_pkg::*;

   localparam int Depth = TableDepthDefault;
   localparam int Feats = FeatureCountDefault;
   localparam int Neigh = NeighborCountDefault;
   localparam int FBits = FeatureBitsDefault;
   localparam longint unsigned ScoreMax = (64'd1 << ScoreBits) - 1;
   localparam int CycleLimit = 3_000_000;

   typedef logic [Feats-1:0][FBits-1:0] vector_type;

   // One input item as it is offered on the request ports.
   typedef struct {
      logic [0:0]           op;
      logic [IndexBits-1:0] index;
      vector_type           vec;
   } knn_item_type;

   typedef struct {
      logic [ScoreBits-1:0] score;
      logic                 anomaly;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [0:0] req_op = OpWrite;
   logic [IndexBits-1:0] req_entry_index = '0;
   vector_type req_vec = '0;
   logic csr_wr_en = 1'b0;
   logic [0:0] csr_index = CsrEntries;
   logic [ScoreBits-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic [ScoreBits-1:0] rsp_score;
   logic rsp_is_anomaly;

   knn_anomaly_score_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_entry_index(req_entry_index),
      .req_feature_0(req_vec[0]), .req_feature_1(req_vec[1]),
      .req_feature_2(req_vec[2]), .req_feature_3(req_vec[3]),
      .req_feature_4(req_vec[4]), .req_feature_5(req_vec[5]),
      .req_feature_6(req_vec[6]), .req_feature_7(req_vec[7]),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_score(rsp_score), .rsp_is_anomaly(rsp_is_anomaly)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the block's state, kept in step with accepted items.
   vector_type      shadow_table [Depth];
   bit              written [Depth];
   longint unsigned shadow_count;
   longint unsigned shadow_threshold;

   knn_item_type pending_items[$];
   score_type    expected_scores[$];
   int           error_count = 0;
   int           cycle_count = 0;

   // Exact integer square root, bit by bit.
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned rem, root, b;
      rem = x;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned vector_distance(vector_type a, vector_type b);
      longint unsigned acc;
      longint d;
      acc = 0;
      for (int i = 0; i < Feats; i++) begin
         d = longint'($signed(a[i])) - longint'($signed(b[i]));
         acc += longint'(d * d);
      end
      return int_sqrt(acc);
   endfunction

   // Score of one query against the shadow table: the sum of the smallest
   // distances, slots never filled counting as zero.
   function automatic score_type predict_score(logic [IndexBits-1:0] index);
      longint unsigned kept [Neigh];
      longint unsigned count, d, sum;
      int filled, big;
      score_type r;
      count = (shadow_count > Depth) ? Depth : shadow_count;
      filled = 0;
      foreach (kept[j]) kept[j] = 0;
      for (longint unsigned i = 0; i < count; i++) begin
         d = vector_distance(shadow_table[index], shadow_table[i]);
         if (filled < Neigh) begin
            kept[filled] = d;
            filled++;
         end else begin
            big = 0;
            for (int j = 1; j < Neigh; j++) if (kept[j] > kept[big]) big = j;
            if (d < kept[big]) kept[big] = d;
         end
      end
      sum = 0;
      foreach (kept[j]) begin
         sum += kept[j];
         if (sum > ScoreMax) sum = ScoreMax;
      end
      r.score = sum[ScoreBits-1:0];
      r.anomaly = (sum > shadow_threshold);
      return r;
   endfunction

   // Driver: offers items from the pending queue in bursts with random gaps.
   // On acceptance the item is applied to the shadow state straight away.
   int burst_left = 4;
   int gap_left = 0;
   always @(posedge clock) begin
      knn_item_type it;
      bit hold;
      if (reset) begin
         start <= 1'b0;
      end else begin
         hold = start && busy;
         if (start && !busy) begin
            it = pending_items.pop_front();
            if (it.op == OpWrite) begin
               shadow_table[it.index] = it.vec;
            end else begin
               expected_scores.push_back(predict_score(it.index));
            end
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items[0];
               start <= 1'b1;
               req_op <= it.op;
               req_entry_index <= it.index;
               req_vec <= it.vec;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  // A gap of zero leaves stretches with no idling at all.
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest expected score.
   always @(posedge clock) begin
      score_type want;
      cycle_count++;
      if (!reset && rsp_valid) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual score %0d anomaly %0d",
                     $time, rsp_score, rsp_is_anomaly);
            error_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_score !== want.score) begin
               $display("%0t: score mismatch, expected %0d, actual %0d",
                        $time, want.score, rsp_score);
               error_count++;
            end
            if (rsp_is_anomaly !== want.anomaly) begin
               $display("%0t: anomaly flag mismatch, expected %0d, actual %0d",
                        $time, want.anomaly, rsp_is_anomaly);
               error_count++;
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The register model is updated in the same step as the write itself.
   task automatic write_register(logic [0:0] index, longint unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= value[ScoreBits-1:0];
      if (index == CsrEntries) shadow_count = value & 64'h7FF;
      else shadow_threshold = value & ScoreMax;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every item has gone in and every result has come back, then
   // lets a write that gives no result drain from the block.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() > 0 || start || busy || expected_scores.size() > 0);
      repeat (40) @(negedge clock);
   endtask

   function automatic vector_type random_vector();
      vector_type v;
      int base;
      case ($urandom_range(0, 3))
         0: foreach (v[i]) v[i] = FBits'($urandom);
         1: foreach (v[i]) v[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: begin
            // Loose clusters around a common point give scores of varied size.
            base = $urandom_range(0, 8191) - 4096;
            foreach (v[i]) v[i] = 16'(base + int'($urandom_range(0, 2047)) - 1024);
         end
      endcase
      return v;
   endfunction

   task automatic queue_write(int index, vector_type v);
      knn_item_type it;
      it.op = OpWrite;
      it.index = IndexBits'(index);
      it.vec = v;
      written[index] = 1'b1;
      @(negedge clock);
      pending_items.push_back(it);
   endtask

   // Query features are ignored by the block, so they carry random noise.
   task automatic queue_query(int index);
      knn_item_type it;
      it.op = OpQuery;
      it.index = IndexBits'(index);
      foreach (it.vec[i]) it.vec[i] = FBits'($urandom);
      @(negedge clock);
      pending_items.push_back(it);
   endtask

   // Makes sure every entry compared by a query at this count has been written.
   task automatic fill_below(int count);
      for (int i = 0; i < count && i < Depth; i++)
         if (!written[i]) queue_write(i, random_vector());
   endtask

   initial begin
      int count, idx, items;
      vector_type v;
      shadow_count = 0;
      shadow_threshold = 0;
      foreach (written[i]) written[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a query with nothing to compare against, then the
      // feature extremes against each other, so that distances reach their largest.
      v = '0;
      foreach (v[i]) v[i] = 16'h8000;
      queue_write(0, v);
      queue_query(0);
      wait_idle();
      write_register(CsrEntries, 4);
      write_register(CsrThreshold, 0);
      foreach (v[i]) v[i] = 16'h7FFF;
      queue_write(1, v);
      queue_write(2, '0);
      foreach (v[i]) v[i] = (i % 2) ? 16'h8000 : 16'h7FFF;
      queue_write(3, v);
      foreach (v[i]) v[i] = 16'h0001;
      queue_write(1023, v);
      for (int i = 0; i < 4; i++) queue_query(i);
      wait_idle();
      write_register(CsrThreshold, ScoreMax);
      for (int i = 0; i < 4; i++) queue_query(i);
      // Fewer entries than neighbour slots leaves empty slots at zero.
      wait_idle();
      write_register(CsrEntries, 2);
      write_register(CsrThreshold, 1);
      queue_query(1);
      queue_query(0);
      queue_query(1023);
      wait_idle();
      write_register(CsrEntries, 1);
      queue_query(3);

      // Random phases, mostly with a small table so that queries stay short.
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         count = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 48);
         write_register(CsrEntries, count);
         case ($urandom_range(0, 3))
            0: write_register(CsrThreshold, 0);
            1: write_register(CsrThreshold, ScoreMax);
            default: write_register(CsrThreshold, $urandom_range(0, 60000));
         endcase
         fill_below(count);
         for (items = 0; items < 50; items++) begin
            if ($urandom_range(0, 2) == 0) begin
               queue_write($urandom_range(0, Depth - 1), random_vector());
            end else begin
               do idx = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                             : $urandom_range(0, Depth - 1);
               while (!written[idx]);
               queue_query(idx);
            end
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
